@@ src/stvk_pkg.sv @@
package stvk_pkg;

  // Width of one intermediate matrix entry, clamped to [-2^30, 2^30 - 1]
  localparam int INNER_W = 31;
  localparam logic signed [63:0] INNER_MAX = 64'sd1073741823;
  localparam logic signed [63:0] INNER_MIN = -64'sd1073741824;

  // Cycles from an accepted item to its result strobe
  localparam int LATENCY = 14;

  // Configuration register indexes
  localparam logic REG_SHEAR = 1'b0;
  localparam logic REG_LAME  = 1'b1;

  typedef logic signed [INNER_W-1:0] inner_t;
  typedef inner_t imat_t [3][3];

  typedef struct packed {
    logic        kind;
    logic [62:0] edge_row0;
    logic [62:0] edge_row1;
    logic [62:0] edge_row2;
    logic [62:0] delta_row0;
    logic [62:0] delta_row1;
    logic [62:0] delta_row2;
    logic [62:0] rest_inv_row0;
    logic [62:0] rest_inv_row1;
    logic [62:0] rest_inv_row2;
    logic [31:0] rest_volume;
  } item_t;

  typedef struct packed {
    logic [62:0] force_v1;
    logic [62:0] force_v2;
    logic [62:0] force_v3;
    logic [62:0] force_v0;
    logic        overflow;
  } result_t;

  // Round to nearest, ties toward plus infinity
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic inner_ovf(input logic signed [63:0] v);
    return (v > INNER_MAX) || (v < INNER_MIN);
  endfunction

  function automatic inner_t inner_clamp(input logic signed [63:0] v);
    if (v > INNER_MAX) return INNER_MAX[INNER_W-1:0];
    if (v < INNER_MIN) return INNER_MIN[INNER_W-1:0];
    return v[INNER_W-1:0];
  endfunction

endpackage

@@ src/stvk_tet_element_force.sv @@
// Channel   Handshake            Payload             Width
// item      start / busy         item_t              nine rows, kind, volume
// result    done (strobe)        result_t            four packed forces, flag
// config    cfg_write            cfg_index, cfg_data 1-bit index, 32-bit data
//
// Fourteen-stage pipeline: one beat enters per cycle while busy is low, and
// its result leaves the last stage with a strobe on done. Each stage holds
// a bank of multipliers, a bank of sum, round and clamp, or both (stages 5
// and 6); the strain and matrix products set the depth. Reset clears all
// valid bits and loads mu = lambda = 1.0; busy is high in reset and in the
// cycle after it. The receiver cannot stall, so the pipeline never holds.
module stvk_tet_element_force
  import stvk_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 21
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        done,
  output result_t     result,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int FRAC = CW - 7;
  localparam logic signed [63:0] OMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] OMIN = -(64'sd1 <<< (CW - 1));

  typedef logic signed [CW-1:0] comp_t;
  typedef comp_t cmat_t [3][3];
  typedef logic signed [2*CW-1:0] nprod_t [3][3][3];
  typedef logic signed [63:0] wprod_t [3][3][3];
  typedef logic signed [63:0] wmat_t [3][3];

  function automatic logic out_ovf(input logic signed [63:0] v);
    return (v > OMAX) || (v < OMIN);
  endfunction

  function automatic comp_t out_clamp(input logic signed [63:0] v);
    if (v > OMAX) return OMAX[CW-1:0];
    if (v < OMIN) return OMIN[CW-1:0];
    return v[CW-1:0];
  endfunction

  logic [31:0] shear;
  logic [31:0] lame;
  logic [LATENCY-1:0] vld;
  logic accept;

  // Configuration and control
  always_ff @(posedge clk) begin
    if (rst) begin
      shear <= 32'd65536;
      lame  <= 32'd65536;
      vld   <= '0;
      busy  <= 1'b1;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[LATENCY-2:0], accept};
      if (cfg_write) begin
        case (cfg_index)
          REG_SHEAR: shear <= cfg_data;
          REG_LAME:  lame  <= cfg_data;
          default:   ;
        endcase
      end
    end
  end

  assign accept = start && !busy;
  assign done   = vld[LATENCY-1];

  // Unpack input rows
  cmat_t ds0, dd0, b0;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ds0[0][c] = item.edge_row0[c*CW +: CW];
      ds0[1][c] = item.edge_row1[c*CW +: CW];
      ds0[2][c] = item.edge_row2[c*CW +: CW];
      dd0[0][c] = item.delta_row0[c*CW +: CW];
      dd0[1][c] = item.delta_row1[c*CW +: CW];
      dd0[2][c] = item.delta_row2[c*CW +: CW];
      b0[0][c]  = item.rest_inv_row0[c*CW +: CW];
      b0[1][c]  = item.rest_inv_row1[c*CW +: CW];
      b0[2][c]  = item.rest_inv_row2[c*CW +: CW];
    end
  end

  // Stage 1: products for F = Ds*B and dF = dDs*B
  nprod_t pf1, pd1;
  cmat_t b1, b2, b3, b4, b5, b6, b7, b8, b9;
  logic [31:0] vol1, vol2, vol3, vol4, vol5, vol6, vol7, vol8, vol9, vol10, vol11;
  logic kind1, kind2, kind3, kind4, kind5, kind6, kind7;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++) begin
          pf1[i][j][k] <= ds0[i][k] * b0[k][j];
          pd1[i][j][k] <= dd0[i][k] * b0[k][j];
        end
    b1    <= b0;
    vol1  <= item.rest_volume;
    kind1 <= item.kind;
  end

  // Stage 2: sum, round and clamp F and dF
  imat_t f_next, df_next, f2, df2;
  logic se_next2, sd_next2, se2, sd2;
  wmat_t sf2, sd2w;
  always_comb begin
    se_next2 = 1'b0;
    sd_next2 = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        sf2[i][j] = rnd_shift(64'(pf1[i][j][0]) + 64'(pf1[i][j][1]) + 64'(pf1[i][j][2]),
                              FRAC);
        sd2w[i][j] = rnd_shift(64'(pd1[i][j][0]) + 64'(pd1[i][j][1]) + 64'(pd1[i][j][2]),
                               FRAC);
        f_next[i][j]  = inner_clamp(sf2[i][j]);
        df_next[i][j] = inner_clamp(sd2w[i][j]);
        se_next2 = se_next2 | inner_ovf(sf2[i][j]);
        sd_next2 = sd_next2 | inner_ovf(sd2w[i][j]);
      end
  end

  always_ff @(posedge clk) begin
    f2 <= f_next;
    df2 <= df_next;
    se2 <= se_next2;
    sd2 <= sd_next2;
    b2 <= b1;
    vol2 <= vol1;
    kind2 <= kind1;
  end

  // Stage 3: strain products F[k][i]*F[k][j] and dF[k][i]*F[k][j]
  wprod_t te3, td3;
  imat_t f3, df3;
  logic se3, sd3;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++) begin
          te3[i][j][k] <= 64'(f2[k][i] * f2[k][j]);
          td3[i][j][k] <= 64'(df2[k][i] * f2[k][j]);
        end
    f3 <= f2;
    df3 <= df2;
    se3 <= se2;
    sd3 <= sd2;
    b3 <= b2;
    vol3 <= vol2;
    kind3 <= kind2;
  end

  // Stage 4: strain E and dE with the halving folded into the rounding
  wmat_t ae4, ad4;
  imat_t e_next, de_next, e4, de4, f4, df4;
  logic se_next4, sd_next4, se4, sd4;
  always_comb begin
    se_next4 = se3;
    sd_next4 = sd3;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        ae4[i][j] = te3[i][j][0] + te3[i][j][1] + te3[i][j][2]
                  + te3[j][i][0] + te3[j][i][1] + te3[j][i][2];
        if (i == j)
          ae4[i][j] = ae4[i][j] - (64'sd1 <<< (2 * FRAC + 1));
        ad4[i][j] = td3[i][j][0] + td3[i][j][1] + td3[i][j][2]
                  + td3[j][i][0] + td3[j][i][1] + td3[j][i][2];
        ae4[i][j] = rnd_shift(ae4[i][j], FRAC + 2);
        ad4[i][j] = rnd_shift(ad4[i][j], FRAC + 2);
        e_next[i][j]  = inner_clamp(ae4[i][j]);
        de_next[i][j] = inner_clamp(ad4[i][j]);
        se_next4 = se_next4 | inner_ovf(ae4[i][j]);
        sd_next4 = sd_next4 | inner_ovf(ad4[i][j]);
      end
  end

  always_ff @(posedge clk) begin
    e4 <= e_next;
    de4 <= de_next;
    se4 <= se_next4;
    sd4 <= sd_next4;
    f4 <= f3;
    df4 <= df3;
    b4 <= b3;
    vol4 <= vol3;
    kind4 <= kind3;
  end

  // Stage 5: traces and mu products
  inner_t tre_a, trd_a, tre_next, trd_next, tre5, trd5;
  logic se_next5, sd_next5, se5, sd5;
  wmat_t mue5, mud5;
  imat_t f5, df5;
  always_comb begin
    tre_a = inner_clamp(64'(e4[0][0]) + 64'(e4[1][1]));
    trd_a = inner_clamp(64'(de4[0][0]) + 64'(de4[1][1]));
    tre_next = inner_clamp(64'(tre_a) + 64'(e4[2][2]));
    trd_next = inner_clamp(64'(trd_a) + 64'(de4[2][2]));
    se_next5 = se4 | inner_ovf(64'(e4[0][0]) + 64'(e4[1][1]))
             | inner_ovf(64'(tre_a) + 64'(e4[2][2]));
    sd_next5 = sd4 | inner_ovf(64'(de4[0][0]) + 64'(de4[1][1]))
             | inner_ovf(64'(trd_a) + 64'(de4[2][2]));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        mue5[i][j] <= $signed({1'b0, shear}) * e4[i][j];
        mud5[i][j] <= $signed({1'b0, shear}) * de4[i][j];
      end
    tre5 <= tre_next;
    trd5 <= trd_next;
    se5 <= se_next5;
    sd5 <= sd_next5;
    f5 <= f4;
    df5 <= df4;
    b5 <= b4;
    vol5 <= vol4;
    kind5 <= kind4;
  end

  // Stage 6: lambda products and rounded 2 mu e
  logic signed [63:0] lte6, ltd6;
  wmat_t rve6, rvd6;
  imat_t ve_next, vd_next, ve6, vd6, f6, df6;
  logic se_next6, sd_next6, se6, sd6;
  always_comb begin
    se_next6 = se5;
    sd_next6 = sd5;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        rve6[i][j] = rnd_shift(mue5[i][j], 15);
        rvd6[i][j] = rnd_shift(mud5[i][j], 15);
        ve_next[i][j] = inner_clamp(rve6[i][j]);
        vd_next[i][j] = inner_clamp(rvd6[i][j]);
        se_next6 = se_next6 | inner_ovf(rve6[i][j]);
        sd_next6 = sd_next6 | inner_ovf(rvd6[i][j]);
      end
  end

  always_ff @(posedge clk) begin
    lte6 <= $signed({1'b0, lame}) * tre5;
    ltd6 <= $signed({1'b0, lame}) * trd5;
    ve6 <= ve_next;
    vd6 <= vd_next;
    se6 <= se_next6;
    sd6 <= sd_next6;
    f6 <= f5;
    df6 <= df5;
    b6 <= b5;
    vol6 <= vol5;
    kind6 <= kind5;
  end

  // Stage 7: stress S and dS
  logic signed [63:0] rle7, rld7;
  inner_t le7, ld7;
  wmat_t dge7, dgd7;
  imat_t s_next, ds_next, s7, dss7, f7, df7;
  logic se_next7, sd_next7, se7, sd7;
  always_comb begin
    rle7 = rnd_shift(lte6, 16);
    rld7 = rnd_shift(ltd6, 16);
    le7 = inner_clamp(rle7);
    ld7 = inner_clamp(rld7);
    se_next7 = se6 | inner_ovf(rle7);
    sd_next7 = sd6 | inner_ovf(rld7);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        dge7[i][j] = 64'(ve6[i][j]) + 64'(le7);
        dgd7[i][j] = 64'(vd6[i][j]) + 64'(ld7);
        if (i == j) begin
          s_next[i][j]  = inner_clamp(dge7[i][j]);
          ds_next[i][j] = inner_clamp(dgd7[i][j]);
          se_next7 = se_next7 | inner_ovf(dge7[i][j]);
          sd_next7 = sd_next7 | inner_ovf(dgd7[i][j]);
        end else begin
          s_next[i][j]  = ve6[i][j];
          ds_next[i][j] = vd6[i][j];
        end
      end
  end

  always_ff @(posedge clk) begin
    s7 <= s_next;
    dss7 <= ds_next;
    se7 <= se_next7;
    sd7 <= sd_next7;
    f7 <= f6;
    df7 <= df6;
    b7 <= b6;
    vol7 <= vol6;
    kind7 <= kind6;
  end

  // Stage 8: products for P = A*S (+ F*dS in differential mode)
  imat_t a8;
  wprod_t px8, py8;
  logic sat8;
  always_comb begin
    if (kind7) a8 = df7;
    else a8 = f7;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++) begin
          px8[i][j][k] <= 64'(a8[i][k] * s7[k][j]);
          py8[i][j][k] <= kind7 ? 64'(f7[i][k] * dss7[k][j]) : 64'sd0;
        end
    sat8 <= se7 | (kind7 & sd7);
    b8 <= b7;
    vol8 <= vol7;
  end

  // Stage 9: P
  wmat_t ap9;
  imat_t p_next, p9;
  logic sat_next9, sat9;
  always_comb begin
    sat_next9 = sat8;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        ap9[i][j] = rnd_shift(px8[i][j][0] + px8[i][j][1] + px8[i][j][2]
                            + py8[i][j][0] + py8[i][j][1] + py8[i][j][2], FRAC);
        p_next[i][j] = inner_clamp(ap9[i][j]);
        sat_next9 = sat_next9 | inner_ovf(ap9[i][j]);
      end
  end

  always_ff @(posedge clk) begin
    p9 <= p_next;
    sat9 <= sat_next9;
    b9 <= b8;
    vol9 <= vol8;
  end

  // Stage 10: products for Q = P*B^T
  wprod_t pz10;
  logic sat10;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++)
          pz10[i][j][k] <= 64'(p9[i][k] * b9[j][k]);
    sat10 <= sat9;
    vol10 <= vol9;
  end

  // Stage 11: Q
  wmat_t aq11;
  imat_t q_next, q11;
  logic sat_next11, sat11;
  always_comb begin
    sat_next11 = sat10;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        aq11[i][j] = rnd_shift(pz10[i][j][0] + pz10[i][j][1] + pz10[i][j][2], FRAC);
        q_next[i][j] = inner_clamp(aq11[i][j]);
        sat_next11 = sat_next11 | inner_ovf(aq11[i][j]);
      end
  end

  always_ff @(posedge clk) begin
    q11 <= q_next;
    sat11 <= sat_next11;
    vol11 <= vol10;
  end

  // Stage 12: volume products
  wmat_t w12;
  logic sat12;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        w12[i][j] <= $signed({1'b0, vol11}) * q11[i][j];
    sat12 <= sat11;
  end

  // Stage 13: forces on vertices 1-3, indexed [vertex-1][axis]
  wmat_t rf13;
  cmat_t fv_next, fv13;
  logic sat_next13, sat13;
  always_comb begin
    sat_next13 = sat12;
    for (int c = 0; c < 3; c++)
      for (int i = 0; i < 3; i++) begin
        rf13[c][i] = rnd_shift(-w12[i][c], 24);
        fv_next[c][i] = out_clamp(rf13[c][i]);
        sat_next13 = sat_next13 | out_ovf(rf13[c][i]);
      end
  end

  always_ff @(posedge clk) begin
    fv13 <= fv_next;
    sat13 <= sat_next13;
  end

  // Stage 14: vertex 0 and output pack
  logic signed [63:0] s14 [3];
  result_t res_next;
  logic sat_next14;
  always_comb begin
    res_next = '0;
    sat_next14 = sat13;
    for (int i = 0; i < 3; i++) begin
      s14[i] = -(64'(fv13[0][i]) + 64'(fv13[1][i]) + 64'(fv13[2][i]));
      sat_next14 = sat_next14 | out_ovf(s14[i]);
      res_next.force_v1[i*CW +: CW] = fv13[0][i];
      res_next.force_v2[i*CW +: CW] = fv13[1][i];
      res_next.force_v3[i*CW +: CW] = fv13[2][i];
      res_next.force_v0[i*CW +: CW] = out_clamp(s14[i]);
    end
    res_next.overflow = sat_next14;
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

@@ src/stvk_chk.sv @@
module stvk_chk
  import stvk_pkg::*;
#(
  parameter int CW = 21
) (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // Hold off the strobe and keep busy high right after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !done && busy)
    else $error("strobe or ready after reset");

  // Every accepted beat yields a result a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after accepted beat");

  // No result without a matching accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without accepted beat");

  // Drop nothing into the unused high bits of a force
  a_high_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.force_v1 >> (3 * CW)) == 0 && (result.force_v0 >> (3 * CW)) == 0)
    else $error("unused force bits set");

endmodule

bind stvk_tet_element_force stvk_chk #(.CW(COMPONENT_WIDTH)) u_stvk_chk (.*);

@@ tb/sv/tb_stvk_tet_element_force.sv @@
`timescale 1ns / 100ps

module tb_stvk_tet_element_force
  import stvk_pkg::*;
();

  localparam int CW = 21;
  localparam int FB = 14;
  localparam longint ONE = 64'sd1 << FB;
  localparam int IDLE_LIMIT = 2000;

  typedef longint mat_t [3][3];

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } vector_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item;
  logic        done;
  result_t     result;
  logic        cfg_write;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // Typed expectation that travels with the beat on the item port
  logic        item_typed;
  result_t     item_res;

  logic [31:0] mu_q16;
  logic [31:0] lambda_q16;
  bit          clamp_hit;

  result_t     force_q[$];
  int          errors;
  int          idle_cycles;
  int          n_elastic;
  int          n_diff;
  int          n_sat;
  int          n_settings;
  vector_t     vectors[$];

  stvk_tet_element_force DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------- predictor ----------------

  // Round to nearest with ties up: add half, then floor-shift
  function automatic longint round_q(input longint v, input int s);
    longint half;
    half = 64'sd1 << (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic longint sat_to(input longint v, input longint lim);
    if (v > lim - 1) begin
      clamp_hit = 1'b1;
      return lim - 1;
    end
    if (v < -lim) begin
      clamp_hit = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  function automatic longint sat_in(input longint v);
    return sat_to(v, 64'sd1 << 30);
  endfunction

  function automatic longint comp_of(input logic [62:0] w, input int c);
    logic signed [CW-1:0] x;
    x = w[c*CW +: CW];
    return longint'(x);
  endfunction

  function automatic void rows_to_mat(input logic [62:0] r0, r1, r2, output mat_t m);
    for (int c = 0; c < 3; c++) begin
      m[0][c] = comp_of(r0, c);
      m[1][c] = comp_of(r1, c);
      m[2][c] = comp_of(r2, c);
    end
  endfunction

  // o = a*b (b transposed if bt) plus c*d when sum2
  function automatic void mat_prod(input mat_t a, b, input bit bt, input bit sum2,
                                   input mat_t c, d, output mat_t o);
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) begin
          acc += a[i][k] * (bt ? b[j][k] : b[k][j]);
          if (sum2) acc += c[i][k] * d[k][j];
        end
        o[i][j] = sat_in(round_q(acc, FB));
      end
  endfunction

  // Symmetric strain (x^T y + y^T x)/4, minus I/2 for the Green strain when unit
  function automatic void green(input mat_t x, y, input bit unit, output mat_t o);
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += x[k][i] * y[k][j] + y[k][i] * x[k][j];
        if (unit && i == j) acc -= 64'sd1 << (2 * FB + 1);
        o[i][j] = sat_in(round_q(acc, FB + 2));
      end
  endfunction

  function automatic void piola2(input mat_t e, output mat_t o);
    longint tr, lt, v, mu, lm;
    mu = longint'({32'd0, mu_q16});
    lm = longint'({32'd0, lambda_q16});
    tr = sat_in(sat_in(e[0][0] + e[1][1]) + e[2][2]);
    lt = sat_in(round_q(lm * tr, 16));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        v = sat_in(round_q(mu * e[i][j], 15));
        o[i][j] = (i == j) ? sat_in(v + lt) : v;
      end
  endfunction

  function automatic result_t element_force(input item_t it);
    mat_t ds, dd, b, f, df, e, de, s, s2, p, h;
    longint fv[4][3];
    longint vol;
    longint olim;
    logic [62:0] w[4];
    result_t r;
    clamp_hit = 1'b0;
    olim = 64'sd1 << (CW - 1);
    vol = longint'({32'd0, it.rest_volume});
    rows_to_mat(it.edge_row0, it.edge_row1, it.edge_row2, ds);
    rows_to_mat(it.delta_row0, it.delta_row1, it.delta_row2, dd);
    rows_to_mat(it.rest_inv_row0, it.rest_inv_row1, it.rest_inv_row2, b);
    mat_prod(ds, b, 1'b0, 1'b0, b, b, f);
    green(f, f, 1'b1, e);
    piola2(e, s);
    if (it.kind) begin
      mat_prod(dd, b, 1'b0, 1'b0, b, b, df);
      green(df, f, 1'b0, de);
      piola2(de, s2);
      mat_prod(df, s, 1'b0, 1'b1, f, s2, p);
    end else begin
      mat_prod(f, s, 1'b0, 1'b0, f, f, p);
    end
    mat_prod(p, b, 1'b1, 1'b0, b, b, h);
    for (int c = 0; c < 3; c++)
      for (int i = 0; i < 3; i++)
        fv[c + 1][i] = sat_to(round_q(-(vol * h[i][c]), 24), olim);
    for (int i = 0; i < 3; i++)
      fv[0][i] = sat_to(-(fv[1][i] + fv[2][i] + fv[3][i]), olim);
    for (int v = 0; v < 4; v++)
      for (int i = 0; i < 3; i++) w[v][i*CW +: CW] = fv[v][i][CW-1:0];
    r.force_v1 = w[1];
    r.force_v2 = w[2];
    r.force_v3 = w[3];
    r.force_v0 = w[0];
    r.overflow = clamp_hit;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [62:0] row3(input longint a, b, c);
    logic [62:0] w;
    w[0 +: CW] = a[CW-1:0];
    w[CW +: CW] = b[CW-1:0];
    w[2*CW +: CW] = c[CW-1:0];
    return w;
  endfunction

  function automatic item_t make_item(input bit k, input logic [62:0] d0, d1, d2,
                                      input logic [62:0] v0, v1, v2,
                                      input logic [62:0] b0, b1, b2,
                                      input logic [31:0] vol);
    item_t it;
    it.kind = k;
    it.edge_row0 = d0;
    it.edge_row1 = d1;
    it.edge_row2 = d2;
    it.delta_row0 = v0;
    it.delta_row1 = v1;
    it.delta_row2 = v2;
    it.rest_inv_row0 = b0;
    it.rest_inv_row1 = b1;
    it.rest_inv_row2 = b2;
    it.rest_volume = vol;
    return it;
  endfunction

  // Mostly near-unit deformations, with full-range and extreme values mixed in
  function automatic longint rand_comp(input bit diag);
    case ($urandom_range(0, 9))
      0:       return longint'($signed(21'($urandom)));
      1:       return $urandom_range(0, 1) ? (64'sd1 << 20) - 1 : -(64'sd1 << 20);
      2, 3:    return longint'($urandom_range(0, 2 * ONE)) - ONE;
      default: return (diag ? ONE : 0) + longint'($urandom_range(0, 4096)) - 2048;
    endcase
  endfunction

  function automatic logic [62:0] rand_row(input int r);
    return row3(rand_comp(r == 0), rand_comp(r == 1), rand_comp(r == 2));
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it = make_item(1'($urandom_range(0, 1)), rand_row(0), rand_row(1), rand_row(2),
                   63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                   63'({$urandom, $urandom}),
                   rand_row(0), rand_row(1), rand_row(2), 32'd0);
    if ($urandom_range(0, 1)) begin
      it.delta_row0 = rand_row(3);
      it.delta_row1 = rand_row(3);
      it.delta_row2 = rand_row(3);
    end
    case ($urandom_range(0, 5))
      0:       it.rest_volume = $urandom;
      1:       it.rest_volume = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      default: it.rest_volume = $urandom_range(0, 32'h0200_0000);
    endcase
    return it;
  endfunction

  // ---------------- driving ----------------

  task automatic send(input item_t it, input bit typed, input result_t res, input int gap);
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    item_typed <= typed;
    item_res <= res;
    do @(posedge clk); while (busy);
    if (it.kind) n_diff++;
    else n_elastic++;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_SHEAR) mu_q16 = val;
    else lambda_q16 = val;
  endtask

  // ---------------- checking ----------------

  task automatic check_field(input string name, input logic [62:0] exp, act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
      errors++;
    end
  endtask

  // Record each accepted beat's expected forces
  always @(posedge clk) begin
    if (!rst && start && !busy)
      force_q.push_back(item_typed ? item_res : element_force(item));
  end

  // Compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    result_t exp;
    if (!rst && done) begin
      if (force_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, result);
        errors++;
      end else begin
        exp = force_q.pop_front();
        check_field("force_v1", exp.force_v1, result.force_v1);
        check_field("force_v2", exp.force_v2, result.force_v2);
        check_field("force_v3", exp.force_v3, result.force_v3);
        check_field("force_v0", exp.force_v0, result.force_v0);
        check_field("overflow", 63'(exp.overflow), 63'(result.overflow));
        if (result.overflow) n_sat++;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_stvk_tet_element_force NOT OK");
      $finish;
    end
  end

  // ---------------- test sequence ----------------

  initial begin
    logic [62:0] id0, id1, id2, zr, mx, mn;
    result_t zero_res;
    item_t   it;
    vector_t v;
    logic [31:0] mu_set[7];
    logic [31:0] lam_set[7];
    bit      no_gaps;

    rst = 1'b1;
    start = 1'b0;
    item = '0;
    item_typed = 1'b0;
    item_res = '0;
    cfg_write = 1'b0;
    cfg_index = REG_SHEAR;
    cfg_data = '0;
    mu_q16 = 32'd65536;
    lambda_q16 = 32'd65536;
    errors = 0;
    idle_cycles = 0;
    n_elastic = 0;
    n_diff = 0;
    n_sat = 0;
    n_settings = 1;
    zero_res = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    id0 = row3(ONE, 0, 0);
    id1 = row3(0, ONE, 0);
    id2 = row3(0, 0, ONE);
    zr = '0;
    mx = row3((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1);
    mn = row3(-(1 << 20), -(1 << 20), -(1 << 20));

    // Directed rows: zero and undeformed elements give zero force; the rest go to the predictor
    vectors.push_back('{make_item(0, zr, zr, zr, zr, zr, zr, zr, zr, zr, 0), 1, zero_res});
    vectors.push_back('{make_item(1, zr, zr, zr, zr, zr, zr, zr, zr, zr, 32'hFFFF_FFFF),
                        1, zero_res});
    vectors.push_back('{make_item(0, id0, id1, id2, mx, mn, mx, id0, id1, id2, 32'hFFFF_FFFF),
                        1, zero_res});
    vectors.push_back('{make_item(0, id0, id1, id2, zr, zr, zr, id0, id1, id2, 1 << 24),
                        0, zero_res});
    vectors.push_back('{make_item(1, id0, id1, id2, id0, id1, id2, id0, id1, id2, 1 << 24),
                        0, zero_res});
    vectors.push_back('{make_item(0, row3(2 * ONE, 0, 0), id1, id2, zr, zr, zr,
                                  id0, id1, id2, 1 << 24), 0, zero_res});
    vectors.push_back('{make_item(1, row3(ONE, ONE / 4, 0), id1, row3(0, -ONE / 2, ONE),
                                  row3(ONE / 8, 0, -ONE / 8), zr, id2,
                                  id0, id1, id2, 32'h0300_0000), 0, zero_res});
    vectors.push_back('{make_item(0, mx, mx, mx, zr, zr, zr, mx, mx, mx, 32'hFFFF_FFFF),
                        0, zero_res});
    vectors.push_back('{make_item(0, mn, mn, mn, zr, zr, zr, mn, mn, mn, 32'hFFFF_FFFF),
                        0, zero_res});
    vectors.push_back('{make_item(1, mx, mn, mx, mn, mx, mn, mn, mx, mn, 32'hFFFF_FFFF),
                        0, zero_res});
    vectors.push_back('{make_item(1, id0, id1, id2, mx, mx, mx, id0, id1, id2, 1 << 24),
                        0, zero_res});
    vectors.push_back('{make_item(0, row3(-ONE, 0, 0), id1, id2, zr, zr, zr,
                                  id0, id1, id2, 1 << 20), 0, zero_res});
    vectors.push_back('{make_item(1, {63{1'b1}}, {63{1'b1}}, {63{1'b1}}, {63{1'b1}},
                                  {63{1'b1}}, {63{1'b1}}, {63{1'b1}}, {63{1'b1}},
                                  {63{1'b1}}, 32'h8000_0000), 0, zero_res});
    vectors.push_back('{make_item(0, row3(ONE + 100, -37, 5), row3(3, ONE - 90, 11),
                                  row3(-7, 13, ONE + 250), zr, zr, zr,
                                  row3(ONE / 2, 0, 0), row3(0, ONE / 2, 0),
                                  row3(0, 0, ONE / 2), 32'h0000_8000), 0, zero_res});

    // Walk the table back to back, then with gaps
    foreach (vectors[i]) begin
      v = vectors[i];
      send(v.it, v.typed, v.res, (i < 7) ? 0 : $urandom_range(0, 3));
    end
    drain();

    // Register settings per phase, extremes included
    mu_set  = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd32768, $urandom, $urandom_range(0, 32'h0004_0000)};
    lam_set = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd200000, $urandom, $urandom_range(0, 32'h0004_0000)};

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        write_reg(REG_SHEAR, mu_set[ph]);
        write_reg(REG_LAME, lam_set[ph]);
        n_settings++;
      end
      no_gaps = (ph % 3 == 1);
      for (int n = 0; n < 100; n++) begin
        it = rand_item();
        send(it, 1'b0, zero_res, no_gaps ? 0 : $urandom_range(0, 18) * $urandom_range(0, 1));
        // Hold off until the pipeline has emptied once mid-phase
        if (ph == 2 && n == 50) drain();
      end
      drain();
    end

    $display("Covered %0d elastic and %0d differential elements under %0d mu/lambda settings,",
             n_elastic, n_diff, n_settings);
    $display("with %0d saturated results among them.", n_sat);
    if (errors == 0 && force_q.size() == 0) begin
      $display("tb_stvk_tet_element_force OK");
    end else begin
      $display("tb_stvk_tet_element_force NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/stvk_pkg.sv
src/stvk_tet_element_force.sv
src/stvk_chk.sv
tb/sv/tb_stvk_tet_element_force.sv
